### sv/ecgqrs_pkg.sv
// Shared types, constants and codes of the ECG QRS heart rate detector.
package ecgqrs_pkg;

  // Field and counter widths
  localparam int SAMPLE_W   = 24;
  localparam int WIN_W      = 16;
  localparam int CNT_W      = 9;
  localparam int QRS_CNT_W  = 16;
  localparam int OUT_W      = 8;
  localparam int LIMIT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Shared divider: numerator covers the 25-bit span, padded to an even width
  localparam int NUM_W     = 26;
  localparam int DEN_W     = 11;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Block parameter defaults
  localparam int WINDOW_LEN_DEF = 4;
  localparam int SAMPLE_HZ_DEF  = 250;

  // Arithmetic constants
  localparam int PEAK_MAX    = 8388607;
  localparam int FIFTH_DIV   = 5;
  localparam int SEC_PER_MIN = 60;
  localparam int QRS_FACTOR  = 22;
  localparam int PCT         = 100;
  localparam int QRS_SCALE   = QRS_FACTOR * PCT;

  localparam logic signed [SAMPLE_W-1:0] PEAK_LOW_RST  = SAMPLE_W'(PEAK_MAX);
  localparam logic signed [SAMPLE_W-1:0] PEAK_HIGH_RST = -PEAK_LOW_RST;

  // Register reset values
  localparam logic [CNT_W-1:0]   REFRACTORY_RST = CNT_W'(125);
  localparam logic [CNT_W-1:0]   TIMEOUT_RST    = CNT_W'(420);
  localparam logic [LIMIT_W-1:0] QRS_LIMIT_RST  = LIMIT_W'(15);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REFRACTORY = 2'd0,
    CFG_TIMEOUT    = 2'd1,
    CFG_QRS_LIMIT  = 2'd2
  } cfg_reg_e;

  // Detection phases
  typedef enum logic [1:0] {
    PH_SEEK_ONSET = 2'd0,
    PH_SEEK_R     = 2'd1,
    PH_SEEK_FALL  = 2'd2,
    PH_FINISH     = 2'd3
  } phase_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_SPAN_WAIT,
    ST_EVAL,
    ST_POST_WAIT,
    ST_OUT
  } seq_state_e;

  // Second division of an item, if any
  typedef enum logic [1:0] {
    POST_NONE,
    POST_RATE,
    POST_QRS
  } post_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

### sv/ecgqrs_sample_if.sv
// Sample input channel: valid/ready with one signed 24-bit sample.
interface ecgqrs_sample_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ecgqrs_pkg::SAMPLE_W-1:0]    sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### sv/ecgqrs_result_if.sv
// Result output channel: valid/ready with rate, QRS width, beat flag and phase.
interface ecgqrs_result_if;
  logic                          valid;
  logic                          ready;
  logic [ecgqrs_pkg::OUT_W-1:0]  heart_rate;
  logic [ecgqrs_pkg::OUT_W-1:0]  qrs_width;
  logic                          beat_found;
  logic [1:0]                    phase;

  modport source (output valid, output heart_rate, output qrs_width,
                  output beat_found, output phase, input ready);
  modport sink   (input valid, input heart_rate, input qrs_width,
                  input beat_found, input phase, output ready);
endinterface

### sv/ecgqrs_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
interface ecgqrs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ecgqrs_pkg::CFG_IDX_W-1:0]   index;
  logic [ecgqrs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/ecgqrs_div.sv
// Shared unsigned restoring divider, two quotient bits per cycle.
module ecgqrs_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ecgqrs_pkg::div_req_t  req_i,
  output ecgqrs_pkg::div_rsp_t  rsp_o
);

  localparam int NW = ecgqrs_pkg::NUM_W;
  localparam int DW = ecgqrs_pkg::DEN_W;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [ecgqrs_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [NW-1:0]                 num_q, num_d;
  logic [NW-1:0]                 quot_q, quot_d;
  logic [DW-1:0]                 rem_q, rem_d;
  logic [DW-1:0]                 den_q, den_d;

  logic [DW:0]   part1, part2;
  logic          ge1, ge2;
  logic [DW-1:0] rem1, rem2;

  always_comb begin
    part1 = {rem_q, num_q[NW-1]};
    ge1   = part1 >= {1'b0, den_q};
    rem1  = ge1 ? DW'(part1 - {1'b0, den_q}) : DW'(part1);
    part2 = {rem1, num_q[NW-2]};
    ge2   = part2 >= {1'b0, den_q};
    rem2  = ge2 ? DW'(part2 - {1'b0, den_q}) : DW'(part2);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = ecgqrs_pkg::STEP_W'(ecgqrs_pkg::DIV_STEPS - 1);
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      num_d  = {num_q[NW-3:0], 2'b00};
      quot_d = {quot_q[NW-3:0], ge1, ge2};
      rem_d  = rem2;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### sv/ecg_qrs_heart_rate_detector.sv
// ECG QRS detector and heart rate estimator, top level with sequencer.
// Usage:
//   in_if  : one signed 24-bit ECG sample per word. ready is high only while
//            the sequencer is idle, so one sample is processed at a time.
//   out_if : one result word per sample: heart rate (bpm, 0 when unknown or
//            timed out), QRS width, beat flag and detection phase after it.
//   cfg_if : register writes (0 refractory, 1 timeout, 2 QRS limit), always
//            ready; write only while no sample is in flight. Other indexes
//            are dropped.
// Timing: every sample runs span/5 through the shared two-bit-per-cycle
//   divider (13 steps). A beat after the first one, which sets the rate
//   (60*SAMPLE_HZ/interval), or a QRS close under the limit, which sets
//   the width (count*2200/SAMPLE_HZ), reuses the divider once more.
//   One sample is in flight at a time; the next waits for its word to load.
// The result sits in an output register; the next sample is accepted while
//   it waits, and a finished sample holds in the output state until the
//   receiver takes the previous word.
// Reset: registers return to defaults (125, 420, 15), peaks to their
//   extremes, window and counters to zero, phase to seek onset.
module ecg_qrs_heart_rate_detector #(
  parameter int WINDOW_LEN = ecgqrs_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_HZ  = ecgqrs_pkg::SAMPLE_HZ_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ecgqrs_sample_if.sink   in_if,
  ecgqrs_result_if.source out_if,
  ecgqrs_cfg_if.sink      cfg_if
);

  localparam int SW = ecgqrs_pkg::SAMPLE_W;
  localparam int WW = ecgqrs_pkg::WIN_W;
  localparam int CW = ecgqrs_pkg::CNT_W;
  localparam int QW = ecgqrs_pkg::QRS_CNT_W;
  localparam int NW = ecgqrs_pkg::NUM_W;
  localparam int DW = ecgqrs_pkg::DEN_W;
  localparam int OW = ecgqrs_pkg::OUT_W;

  localparam logic [NW-1:0] RateNum  = NW'(ecgqrs_pkg::SEC_PER_MIN * SAMPLE_HZ);
  localparam logic [NW-1:0] QrsScale = NW'(ecgqrs_pkg::QRS_SCALE);
  localparam logic [DW-1:0] HzDen    = DW'(SAMPLE_HZ);
  localparam logic [DW-1:0] FifthDen = DW'(ecgqrs_pkg::FIFTH_DIV);

  // Configuration registers
  logic [CW-1:0]                  refr_q, timeout_q;
  logic [ecgqrs_pkg::LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refr_q    <= ecgqrs_pkg::REFRACTORY_RST;
      timeout_q <= ecgqrs_pkg::TIMEOUT_RST;
      limit_q   <= ecgqrs_pkg::QRS_LIMIT_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        ecgqrs_pkg::CFG_REFRACTORY: refr_q    <= cfg_if.data[CW-1:0];
        ecgqrs_pkg::CFG_TIMEOUT:    timeout_q <= cfg_if.data[CW-1:0];
        ecgqrs_pkg::CFG_QRS_LIMIT:  limit_q   <= cfg_if.data[ecgqrs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_if.ready = 1'b1;

  // Detector state
  ecgqrs_pkg::seq_state_e state_q, state_d;
  ecgqrs_pkg::phase_e     phase_q, phase_d;
  ecgqrs_pkg::post_e      post_q, post_d;
  logic signed [SW-1:0]   peak_hi_q, peak_hi_d;
  logic signed [SW-1:0]   peak_lo_q, peak_lo_d;
  logic [WW-1:0]          win_q [WINDOW_LEN];
  logic [WW-1:0]          win_d [WINDOW_LEN];
  logic [CW-1:0]          interval_q, interval_d;
  logic [QW-1:0]          qrs_cnt_q, qrs_cnt_d;
  logic                   first_q, first_d;
  logic                   qrs_on_q, qrs_on_d;
  logic                   beat_q, beat_d;
  logic [OW-1:0]          rate_q, rate_d;
  logic [OW-1:0]          width_q, width_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic [OW-1:0] out_rate_q, out_width_q;
  logic          out_beat_q;
  logic [1:0]    out_phase_q;

  ecgqrs_pkg::div_req_t div_req;
  ecgqrs_pkg::div_rsp_t div_rsp;

  ecgqrs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Arithmetic on the updated peaks; fifth comes from the divider
  logic signed [SW:0]   span;
  logic [NW-1:0]        fifth;
  logic signed [NW-1:0] thr_full;
  logic [WW-1:0]        thr;
  logic                 above;
  logic [WW-1:0]        diff0;
  logic                 fall;
  logic [WINDOW_LEN-2:0] rise_vec;
  logic [WW-1:0]        rise_diff [WINDOW_LEN-1];
  logic                 rising;
  logic [OW-1:0]        quot_sat;

  always_comb begin
    span     = $signed({peak_hi_q[SW-1], peak_hi_q}) - $signed({peak_lo_q[SW-1], peak_lo_q});
    fifth    = div_rsp.quot;
    thr_full = $signed(NW'(peak_hi_q)) - $signed(fifth);
    // sign-extend peak to full width before subtracting
    thr_full = $signed({{(NW-SW){peak_hi_q[SW-1]}}, peak_hi_q}) - $signed(fifth);
    thr      = thr_full[WW-1:0];
    above    = $signed({1'b0, win_q[WINDOW_LEN-1]}) > $signed({thr[WW-1], thr});
    diff0    = win_q[1] - win_q[0];
    fall     = $signed({{(NW-WW){diff0[WW-1]}}, diff0}) < -$signed(fifth);
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      rise_diff[i] = win_q[i+1] - win_q[i];
      rise_vec[i]  = !rise_diff[i][WW-1] && (rise_diff[i] != '0);
    end
    rising   = &rise_vec;
    quot_sat = (|div_rsp.quot[NW-1:OW]) ? '1 : div_rsp.quot[OW-1:0];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    post_d      = post_q;
    peak_hi_d   = peak_hi_q;
    peak_lo_d   = peak_lo_q;
    win_d       = win_q;
    interval_d  = interval_q;
    qrs_cnt_d   = qrs_cnt_q;
    first_d     = first_q;
    qrs_on_d    = qrs_on_q;
    beat_d      = beat_q;
    rate_d      = rate_q;
    width_d     = width_q;
    div_req     = '0;
    out_load    = 1'b0;
    in_if.ready = 1'b0;

    unique case (state_q)
      ecgqrs_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          if (in_if.sample > peak_hi_q) peak_hi_d = in_if.sample;
          if (in_if.sample < peak_lo_q) peak_lo_d = in_if.sample;
          for (int i = 0; i < WINDOW_LEN - 1; i++) win_d[i] = win_q[i+1];
          win_d[WINDOW_LEN-1] = in_if.sample[WW-1:0];
          state_d = ecgqrs_pkg::ST_SPAN;
        end
      end
      ecgqrs_pkg::ST_SPAN: begin
        div_req.start = 1'b1;
        div_req.num   = NW'($unsigned(span));
        div_req.den   = FifthDen;
        state_d       = ecgqrs_pkg::ST_SPAN_WAIT;
      end
      ecgqrs_pkg::ST_SPAN_WAIT: begin
        if (div_rsp.done) state_d = ecgqrs_pkg::ST_EVAL;
      end
      ecgqrs_pkg::ST_EVAL: begin
        beat_d = 1'b0;
        post_d = ecgqrs_pkg::POST_NONE;
        unique case (phase_q)
          ecgqrs_pkg::PH_SEEK_ONSET: begin
            if (rising) phase_d = ecgqrs_pkg::PH_SEEK_R;
          end
          ecgqrs_pkg::PH_SEEK_R: begin
            if (above && (interval_q > refr_q)) begin
              if (first_q) post_d = ecgqrs_pkg::POST_RATE;
              first_d    = 1'b1;
              interval_d = '0;
              phase_d    = ecgqrs_pkg::PH_SEEK_FALL;
              qrs_on_d   = 1'b1;
              beat_d     = 1'b1;
            end
          end
          ecgqrs_pkg::PH_SEEK_FALL: begin
            if (fall) phase_d = ecgqrs_pkg::PH_FINISH;
          end
          ecgqrs_pkg::PH_FINISH: begin
            if (qrs_cnt_q < QW'(limit_q)) post_d = ecgqrs_pkg::POST_QRS;
            else width_d = '0;
            phase_d   = ecgqrs_pkg::PH_SEEK_ONSET;
            qrs_cnt_d = '0;
            qrs_on_d  = 1'b0;
          end
          default: ;
        endcase
        // timeout: restart detection, QRS counting untouched
        if (interval_d > timeout_q) begin
          first_d    = 1'b0;
          phase_d    = ecgqrs_pkg::PH_SEEK_ONSET;
          peak_hi_d  = ecgqrs_pkg::PEAK_HIGH_RST;
          peak_lo_d  = ecgqrs_pkg::PEAK_LOW_RST;
          rate_d     = '0;
          interval_d = '0;
        end
        if (interval_d != '1) interval_d = interval_d + 1'b1;
        if (qrs_on_d && (qrs_cnt_d != '1)) qrs_cnt_d = qrs_cnt_d + 1'b1;
        // second division uses pre-step count values
        unique case (post_d)
          ecgqrs_pkg::POST_RATE: begin
            div_req.start = 1'b1;
            div_req.num   = RateNum;
            div_req.den   = DW'(interval_q);
            state_d       = ecgqrs_pkg::ST_POST_WAIT;
          end
          ecgqrs_pkg::POST_QRS: begin
            div_req.start = 1'b1;
            div_req.num   = NW'(qrs_cnt_q[ecgqrs_pkg::LIMIT_W-1:0]) * QrsScale;
            div_req.den   = HzDen;
            state_d       = ecgqrs_pkg::ST_POST_WAIT;
          end
          default: state_d = ecgqrs_pkg::ST_OUT;
        endcase
      end
      ecgqrs_pkg::ST_POST_WAIT: begin
        if (div_rsp.done) begin
          if (post_q == ecgqrs_pkg::POST_RATE) rate_d = quot_sat;
          else width_d = quot_sat;
          state_d = ecgqrs_pkg::ST_OUT;
        end
      end
      ecgqrs_pkg::ST_OUT: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ecgqrs_pkg::ST_IDLE;
        end
      end
      default: state_d = ecgqrs_pkg::ST_IDLE;
    endcase

    out_valid_d = out_load ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ecgqrs_pkg::ST_IDLE;
      phase_q     <= ecgqrs_pkg::PH_SEEK_ONSET;
      post_q      <= ecgqrs_pkg::POST_NONE;
      peak_hi_q   <= ecgqrs_pkg::PEAK_HIGH_RST;
      peak_lo_q   <= ecgqrs_pkg::PEAK_LOW_RST;
      for (int i = 0; i < WINDOW_LEN; i++) win_q[i] <= '0;
      interval_q  <= '0;
      qrs_cnt_q   <= '0;
      first_q     <= 1'b0;
      qrs_on_q    <= 1'b0;
      beat_q      <= 1'b0;
      rate_q      <= '0;
      width_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      post_q      <= post_d;
      peak_hi_q   <= peak_hi_d;
      peak_lo_q   <= peak_lo_d;
      win_q       <= win_d;
      interval_q  <= interval_d;
      qrs_cnt_q   <= qrs_cnt_d;
      first_q     <= first_d;
      qrs_on_q    <= qrs_on_d;
      beat_q      <= beat_d;
      rate_q      <= rate_d;
      width_q     <= width_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rate_q  <= rate_q;
      out_width_q <= width_q;
      out_beat_q  <= beat_q;
      out_phase_q <= phase_q;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.heart_rate = out_rate_q;
  assign out_if.qrs_width  = out_width_q;
  assign out_if.beat_found = out_beat_q;
  assign out_if.phase      = out_phase_q;

  // Divider is never restarted mid-run
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A new result word only comes out of the output state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ecgqrs_pkg::ST_OUT))
    else $error("result word loaded outside output state");

  // A beat always leaves the detector seeking the fall
  a_beat_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecgqrs_pkg::ST_OUT && beat_q) |-> (phase_q == ecgqrs_pkg::PH_SEEK_FALL))
    else $error("beat without fall phase");

  // A beat restarts the interval count
  a_beat_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecgqrs_pkg::ST_OUT && beat_q) |-> (interval_q == CW'(1)))
    else $error("interval not restarted on beat");

endmodule

### dv/ecg_qrs_heart_rate_detector_test.sv
// Self-checking testbench for the ECG QRS heart rate detector: mirror predictor and scoreboard.
`timescale 1ns / 1ps

module ecg_qrs_heart_rate_detector_test;
  import ecgqrs_pkg::*;

  localparam int STALL_LIMIT  = 4000;  // cycles with no word moving on any channel
  localparam int DRAIN_CYCLES = 64;    // settle time after the last result word
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 10;
  localparam int RATE_NUM     = SEC_PER_MIN * SAMPLE_HZ_DEF;
  localparam int OUT_MAX      = (1 << OUT_W) - 1;
  localparam int SINCE_MAX    = (1 << CNT_W) - 1;
  localparam int QRS_LEN_MAX  = (1 << QRS_CNT_W) - 1;
  localparam int LAST         = WINDOW_LEN_DEF - 1;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // What one sample should produce on the result channel.
  typedef struct {
    logic [OUT_W-1:0] bpm;
    logic [OUT_W-1:0] qrs_ms;
    logic             beat;
    phase_e           ph;
  } beat_report_t;

  logic clk_i;
  logic rst_ni;

  ecgqrs_sample_if sample_if ();
  ecgqrs_result_if result_if ();
  ecgqrs_cfg_if    reg_if ();

  ecg_qrs_heart_rate_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (sample_if),
    .out_if (result_if),
    .cfg_if (reg_if)
  );

  // Mirror of the detector state and its registers.
  longint           pk_hi;
  longint           pk_lo;
  int               thr_lvl;
  logic [WIN_W-1:0] win [WINDOW_LEN_DEF];
  phase_e           det_phase;
  int               since_beat;
  bit               had_beat;
  bit               qrs_open;
  int               qrs_len;
  int               bpm;
  int               qrs_ms;
  int               refr_len;
  int               tmo_len;
  int               qrs_cap;

  logic signed [SAMPLE_W-1:0] sample_queue [$];  // samples not yet on the wire
  beat_report_t               report_queue [$];  // results still owed by the block
  beat_report_t               due;

  int queued_total;
  int mismatches;
  bit calm;          // phase without gaps or stalls
  int gap_left;
  int stall_left;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predictor: one sample in, the expected result word out.
  function automatic beat_report_t advance_detector(input logic signed [SAMPLE_W-1:0] smp);
    beat_report_t     rpt;
    longint           s;
    longint           fifth;
    logic [WIN_W-1:0] d16;
    int               newest;
    int               quo;
    int               i;
    bit               rising;
    s = smp;
    if (s > pk_hi) pk_hi = s;
    if (s < pk_lo) pk_lo = s;
    fifth = (pk_hi - pk_lo) / FIFTH_DIV;
    d16 = WIN_W'(pk_hi - fifth);
    thr_lvl = $signed(d16);

    for (i = 0; i < LAST; i++) win[i] = win[i + 1];
    win[LAST] = smp[WIN_W-1:0];

    rpt.beat = 1'b0;
    case (det_phase)
      PH_SEEK_ONSET: begin
        // onset needs every neighbor step in the window to be strictly rising
        rising = 1'b1;
        for (i = 0; i < LAST; i++) begin
          d16 = win[i + 1] - win[i];
          if ($signed(d16) <= 0) rising = 1'b0;
        end
        if (rising) det_phase = PH_SEEK_R;
      end
      PH_SEEK_R: begin
        // newest entry is compared as unsigned 16 bit against the signed level
        newest = win[LAST];
        if (newest > thr_lvl && since_beat > refr_len) begin
          if (had_beat) begin
            quo = RATE_NUM / since_beat;
            bpm = (quo > OUT_MAX) ? OUT_MAX : quo;
          end
          had_beat   = 1'b1;
          since_beat = 0;
          det_phase  = PH_SEEK_FALL;
          qrs_open   = 1'b1;
          rpt.beat   = 1'b1;
        end
      end
      PH_SEEK_FALL: begin
        d16 = win[1] - win[0];
        if ($signed(d16) < -fifth) det_phase = PH_FINISH;
      end
      default: begin
        if (qrs_len < qrs_cap) begin
          quo = qrs_len * QRS_SCALE / SAMPLE_HZ_DEF;
          qrs_ms = (quo > OUT_MAX) ? OUT_MAX : quo;
        end else begin
          qrs_ms = 0;
        end
        det_phase = PH_SEEK_ONSET;
        qrs_len   = 0;
        qrs_open  = 1'b0;
      end
    endcase

    // timeout restarts detection but leaves the QRS counter running
    if (since_beat > tmo_len) begin
      had_beat   = 1'b0;
      det_phase  = PH_SEEK_ONSET;
      pk_hi      = PEAK_HIGH_RST;
      pk_lo      = PEAK_LOW_RST;
      bpm        = 0;
      thr_lvl    = 0;
      since_beat = 0;
    end
    if (since_beat < SINCE_MAX) since_beat++;
    if (qrs_open && qrs_len < QRS_LEN_MAX) qrs_len++;

    rpt.bpm    = OUT_W'(bpm);
    rpt.qrs_ms = OUT_W'(qrs_ms);
    rpt.ph     = det_phase;
    return rpt;
  endfunction

  // Mostly zero, sometimes a few cycles, rarely long.
  function automatic int pick_gap(input int long_max);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, long_max);
  endfunction

  task automatic push_sample(input int v);
    sample_queue.push_back(SAMPLE_W'(v));
    queued_total++;
  endtask

  // One beat: steady ramp, peak, steep drop, then baseline spaced around the
  // refractory gap, now and then stretched past the timeout.
  task automatic push_beat();
    int off;
    int amp;
    int k;
    int len;
    int j;
    off = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 2000))
                                       : -int'($urandom_range(0, 3000));
    amp = $urandom_range(200, 20000);
    k = $urandom_range(4, 7);
    for (j = 1; j <= k; j++) push_sample(off + amp * j / k);
    push_sample(off + amp / 3);
    push_sample(off - amp / 4);
    push_sample(off);
    len = refr_len - k + int'($urandom_range(0, 30)) - 6;
    if (tmo_len < 200 && $urandom_range(0, 7) == 0) len = tmo_len + int'($urandom_range(0, 10));
    if (len > 150) len = 150;
    if (len < 0) len = 0;
    for (j = 0; j < len; j++) push_sample(off + int'($urandom_range(0, 6)) - 3);
  endtask

  // Random part of one settings phase: mostly beats, some noise and broken shapes.
  task automatic build_phase(input int budget);
    int stop_at;
    int r;
    int n;
    int j;
    int off;
    int amp;
    stop_at = queued_total + budget;
    while (queued_total < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        push_beat();
      end else if (r < 88) begin
        // full-range noise, reaches every sample bit
        n = $urandom_range(1, 4);
        for (j = 0; j < n; j++) push_sample(int'($urandom));
      end else if (r < 94) begin
        // slow descent keeps the fall search open, stretches the QRS count
        off = $urandom_range(0, 1000);
        amp = $urandom_range(2000, 16000);
        for (j = 1; j <= 5; j++) push_sample(off + amp * j / 5);
        n = $urandom_range(30, 40);
        for (j = 1; j <= n; j++) push_sample(off + amp - amp * j / 60);
        push_sample(off - amp / 2);
        push_sample(off);
      end else begin
        // onset that stalls into a plateau
        off = $urandom_range(0, 3000);
        push_sample(off);
        push_sample(off + 50);
        push_sample(off + 100);
        n = $urandom_range(5, 20);
        for (j = 0; j < n; j++) push_sample(off + 100);
      end
    end
  endtask

  // Idle: nothing queued, nothing on the wire, nothing owed.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || sample_if.valid || report_queue.size() != 0);
  endtask

  // Call at a rising edge; leaves valid high so writes can go back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= val;
    @(posedge clk_i);
    while (!reg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_REFRACTORY: refr_len = val;
      CFG_TIMEOUT:    tmo_len  = val;
      CFG_QRS_LIMIT:  qrs_cap  = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sample driver: pops the pending queue, predicts each word as it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
      gap_left        <= 0;
    end else begin
      if (sample_if.valid && sample_if.ready)
        report_queue.push_back(advance_detector(sample_if.sample));
      if (!sample_if.valid || sample_if.ready) begin
        if (gap_left > 0) begin
          gap_left        <= gap_left - 1;
          sample_if.valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          sample_if.valid  <= 1'b1;
          sample_if.sample <= sample_queue.pop_front();
          gap_left         <= pick_gap(40);
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken word with the oldest prediction,
  // stalls ready at random so results back up in the output register.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (report_queue.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual rate %0d width %0d beat %0d phase %0d",
                   $time, result_if.heart_rate, result_if.qrs_width,
                   result_if.beat_found, result_if.phase);
          mismatches++;
        end else begin
          due = report_queue.pop_front();
          check_field("heart_rate", due.bpm, result_if.heart_rate);
          check_field("qrs_width", due.qrs_ms, result_if.qrs_width);
          check_field("beat_found", OUT_W'(due.beat), OUT_W'(result_if.beat_found));
          check_field("phase", OUT_W'(due.ph), OUT_W'(result_if.phase));
        end
      end
      if (stall_left > 0) begin
        stall_left      <= stall_left - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        stall_left      <= pick_gap(60);
      end
    end
  end

  // Watchdog: a run where no word moves for too long is hung.
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
        (reg_if.valid && reg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    int r;
    int t;
    int q;
    rst_ni           = 1'b0;
    sample_if.valid  = 1'b0;
    sample_if.sample = '0;
    result_if.ready  = 1'b0;
    reg_if.valid     = 1'b0;
    reg_if.index     = '0;
    reg_if.data      = '0;
    idle_cycles      = 0;
    mismatches       = 0;
    queued_total     = 0;
    calm             = 1'b0;

    // mirror starts from the reset state
    refr_len   = REFRACTORY_RST;
    tmo_len    = TIMEOUT_RST;
    qrs_cap    = QRS_LIMIT_RST;
    pk_hi      = PEAK_HIGH_RST;
    pk_lo      = PEAK_LOW_RST;
    thr_lvl    = 0;
    foreach (win[i]) win[i] = '0;
    det_phase  = PH_SEEK_ONSET;
    since_beat = 0;
    had_beat   = 1'b0;
    qrs_open   = 1'b0;
    qrs_len    = 0;
    bpm        = 0;
    qrs_ms     = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: sample extremes and 16-bit wrap points under reset settings.
    push_sample(PEAK_MAX);
    push_sample(-PEAK_MAX - 1);
    push_sample(0);
    push_sample(-1);
    push_sample(32767);
    push_sample(32768);
    push_sample(65535);
    push_sample(-65536);
    wait_idle();

    // Short refractory and timeout, widest QRS limit, plus a dropped write.
    @(posedge clk_i);
    write_reg(CFG_REFRACTORY, 2);
    write_reg(CFG_TIMEOUT, 40);
    write_reg(CFG_QRS_LIMIT, 255);
    write_reg(CFG_SPARE, $urandom_range(0, 511));
    reg_if.valid <= 1'b0;
    // two clean beats: ramp to a peak, steep drop, back to baseline
    repeat (2) begin
      push_sample(100);
      push_sample(200);
      push_sample(300);
      push_sample(400);
      push_sample(500);
      push_sample(50);
      push_sample(-300);
      push_sample(0);
      push_sample(0);
    end
    wait_idle();

    // Random phases, each under its own register settings.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin r = 0;   t = 511; q = 255; end
        1: begin r = 511; t = 0;   q = 0;   end
        2: begin r = 20;  t = 120; q = 15;  end
        3: begin r = 70;  t = 200; q = 40;  end
        4: begin r = 511; t = 511; q = 1;   end
        default: begin
          r = $urandom_range(0, 90);
          t = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 511))
                                          : r + int'($urandom_range(10, 150));
          q = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 30))
                                          : int'($urandom_range(0, 255));
        end
      endcase
      calm = (ph == 0) || ($urandom_range(0, 4) == 0);
      @(posedge clk_i);
      write_reg(CFG_QRS_LIMIT, q);
      write_reg(CFG_TIMEOUT, t);
      write_reg(CFG_REFRACTORY, r);
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, $urandom_range(0, 511));
      reg_if.valid <= 1'b0;
      build_phase((ph == 1 || ph == 4) ? 60 : PHASE_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && report_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
